// File: hw/rtl/per_thread_counter_delta_unit_defines.svh
// Assertion macros for the per-thread counter delta unit.
// Used by the checker module; expects signals named clock and reset in scope.
`ifndef PER_THREAD_COUNTER_DELTA_UNIT_DEFINES_SVH
`define PER_THREAD_COUNTER_DELTA_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define PTCD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptcd assertion failed");

// Consequent in the cycle after the antecedent.
`define PTCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptcd assertion failed");

`endif

// File: hw/rtl/ptcd_pkg.sv
// Shared constants, beat types and control structs for the counter delta unit.
// No dependencies; imported by every module of the block except ptcd_ram.
package ptcd_pkg;

   localparam int MAX_THREADS  = 64;
   localparam int MAX_COUNTERS = 8;

   localparam int THREAD_W    = 23;
   localparam int VALUE_W     = 64;
   localparam int COUNT_IN_W  = 4;
   localparam int SEQ_W       = 64;
   localparam int SLOT_OUT_W  = 3;

   localparam int ENTRY_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int USED_W   = $clog2(MAX_THREADS + 1);
   localparam int SLOT_W   = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
   localparam int CNT_W    = $clog2(MAX_COUNTERS + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int PRIOR_DEPTH = MAX_THREADS * MAX_COUNTERS;
   localparam int PRIOR_AW = (PRIOR_DEPTH > 1) ? $clog2(PRIOR_DEPTH) : 1;

   localparam logic STATUS_ACCEPTED = 1'b0;
   localparam logic STATUS_FULL     = 1'b1;

   typedef struct packed {
      logic [THREAD_W-1:0]   thread_id;
      logic [THREAD_W-1:0]   process_id;
      logic [VALUE_W-1:0]    counter_value;
      logic [COUNT_IN_W-1:0] sample_count;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [SEQ_W-1:0]      sequence_res;
      logic [THREAD_W-1:0]   thread_out;
      logic [THREAD_W-1:0]   process_out;
      logic [SLOT_OUT_W-1:0] slot_out;
      logic [VALUE_W-1:0]    delta;
      logic                  last_of_sample;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic alloc;
      logic hit;
      logic reject;
      logic calc;
   } cmd_type;

   typedef struct packed {
      logic first_of_sample;
      logic scan_end;
      logic table_full;
      logic scan_match;
   } stat_type;

endpackage

// File: hw/rtl/ptcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ptcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ptcd_ctrl.sv
// Controller state machine: sequences lookup, allocation or rejection, read and update.
// Depends on ptcd_pkg for the command and status structs.
module ptcd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ptcd_pkg::stat_type stat,
   output ptcd_pkg::cmd_type  cmd,
   output logic               busy
);
   import ptcd_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_CALC = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.first_of_sample ? ST_LOOK : ST_READ;
            end
         end
         ST_LOOK: begin
            if (stat.scan_end) begin
               if (stat.table_full) begin
                  cmd.reject = 1'b1;
               end else begin
                  cmd.alloc = 1'b1;
               end
               state_in = ST_READ;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.scan_match) begin
               cmd.hit  = 1'b1;
               state_in = ST_READ;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_LOOK;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hw/rtl/ptcd_datapath.sv
// Datapath: beat registers, thread, count and prior-reading RAMs, delta logic.
// Depends on ptcd_pkg and ptcd_ram.
module ptcd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ptcd_pkg::req_type  req_item,
   input  ptcd_pkg::cmd_type  cmd,
   output ptcd_pkg::stat_type stat,
   output logic               rsp_valid,
   output ptcd_pkg::rsp_type  rsp_item
);
   import ptcd_pkg::*;

   req_type             item_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [USED_W-1:0]   scan_idx_ff;
   logic [USED_W-1:0]   used_ff;
   logic [ENTRY_W-1:0]  current_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic                rejected_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [THREAD_W-1:0] thread_rdata;
   logic [CNT_W-1:0]    count_rdata;
   logic [VALUE_W-1:0]  prior_rdata;

   logic [CNT_W-1:0]    cnt_sat;
   logic                last;
   logic                have_prior;
   logic [VALUE_W-1:0]  delta;
   logic [PRIOR_AW-1:0] prior_addr;
   logic                count_we;
   logic [ENTRY_W-1:0]  count_waddr;
   logic [CNT_W-1:0]    count_wdata;
   logic                prior_we;

   assign cnt_sat = ((SUM_W + 1)'(item_ff.sample_count) > (SUM_W + 1)'(MAX_COUNTERS)) ?
                    CNT_W'(MAX_COUNTERS) : CNT_W'(item_ff.sample_count);

   assign last = (cnt_sat == '0) ||
                 ((SUM_W'(slot_ff) + SUM_W'(1)) >= SUM_W'(cnt_sat));
   assign have_prior = SUM_W'(slot_ff) < SUM_W'(count_rdata);

   always_comb begin
      if (rejected_ff || (cnt_sat == '0)) begin
         delta = '0;
      end else if (have_prior && (item_ff.counter_value >= prior_rdata)) begin
         delta = item_ff.counter_value - prior_rdata;
      end else begin
         delta = item_ff.counter_value;
      end
   end

   assign prior_addr = PRIOR_AW'(current_ff) * PRIOR_AW'(MAX_COUNTERS) + PRIOR_AW'(slot_ff);
   assign prior_we   = cmd.calc && !rejected_ff && (cnt_sat != '0);

   assign count_we    = cmd.alloc || (cmd.calc && last && !rejected_ff);
   assign count_waddr = cmd.alloc ? used_ff[ENTRY_W-1:0] : current_ff;
   assign count_wdata = cmd.alloc ? '0 : cnt_sat;

   ptcd_ram #(.WIDTH(THREAD_W), .DEPTH(MAX_THREADS)) u_thread_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc),
      .wr_addr (used_ff[ENTRY_W-1:0]),
      .wr_data (item_ff.thread_id),
      .rd_addr (scan_idx_ff[ENTRY_W-1:0]),
      .rd_data (thread_rdata)
   );

   ptcd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_THREADS)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (count_waddr),
      .wr_data (count_wdata),
      .rd_addr (current_ff),
      .rd_data (count_rdata)
   );

   ptcd_ram #(.WIDTH(VALUE_W), .DEPTH(PRIOR_DEPTH)) u_prior_ram (
      .clock   (clock),
      .wr_en   (prior_we),
      .wr_addr (prior_addr),
      .wr_data (item_ff.counter_value),
      .rd_addr (prior_addr),
      .rd_data (prior_rdata)
   );

   assign stat.first_of_sample = (slot_ff == '0);
   assign stat.scan_end        = (scan_idx_ff == used_ff);
   assign stat.table_full      = (used_ff == USED_W'(MAX_THREADS));
   assign stat.scan_match      = (thread_rdata == item_ff.thread_id);

   always_comb begin
      rsp_in.status         = rejected_ff ? STATUS_FULL : STATUS_ACCEPTED;
      rsp_in.sequence_res   = rejected_ff ? '0 : seq_ff;
      rsp_in.thread_out     = item_ff.thread_id;
      rsp_in.process_out    = item_ff.process_id;
      rsp_in.slot_out       = SLOT_OUT_W'(slot_ff);
      rsp_in.delta          = delta;
      rsp_in.last_of_sample = last;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      if (cmd.calc) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         scan_idx_ff  <= '0;
         used_ff      <= '0;
         current_ff   <= '0;
         seq_ff       <= '0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.calc;
         if (cmd.load) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + USED_W'(1);
         end
         if (cmd.alloc) begin
            used_ff    <= used_ff + USED_W'(1);
            current_ff <= used_ff[ENTRY_W-1:0];
         end else if (cmd.hit) begin
            current_ff <= scan_idx_ff[ENTRY_W-1:0];
         end
         if (cmd.alloc || cmd.hit) begin
            seq_ff      <= seq_ff + SEQ_W'(1);
            rejected_ff <= 1'b0;
         end else if (cmd.reject) begin
            rejected_ff <= 1'b1;
         end
         if (cmd.calc) begin
            slot_ff <= last ? '0 : slot_ff + SLOT_W'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: hw/rtl/per_thread_counter_delta_unit.sv
// Top level of the per-thread counter delta unit: controller plus datapath.
// Depends on ptcd_pkg, ptcd_ctrl, ptcd_datapath and ptcd_ram.
//
//   Channel   Ports                 Handshake
//   request   start, busy, req_item beat taken when start is high and busy is low
//   response  rsp_valid, rsp_item   one-cycle strobe, cannot be held off
//
// A continuation beat of a sample passes through the READ and CALC states only.
// The first beat walks the thread RAM through a LOOK and a CMP state per entry,
// then READ and CALC, on a hit as well as when allocating or rejecting.
// The result is strobed in the first cycle with busy low; a new beat may be taken then.
// Reset is synchronous and clears the control state; the RAMs are not cleared.
module per_thread_counter_delta_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptcd_pkg::req_type req_item,
   output logic              rsp_valid,
   output ptcd_pkg::rsp_type rsp_item
);
   import ptcd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ptcd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   ptcd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// File: hw/rtl/ptcd_checker.sv
// Port-level checker for the per-thread counter delta unit, with its bind.
// Depends on ptcd_pkg and per_thread_counter_delta_unit_defines.svh.
`include "per_thread_counter_delta_unit_defines.svh"

module ptcd_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ptcd_pkg::rsp_type rsp_item
);
   import ptcd_pkg::*;

   logic reject_beat;
   logic reject_clean;

   assign reject_beat  = rsp_valid && (rsp_item.status == STATUS_FULL);
   assign reject_clean = (rsp_item.sequence_res == '0) && (rsp_item.delta == '0);

   `PTCD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `PTCD_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid)
   `PTCD_ASSERT_SAME(a_strobe_idle, rsp_valid, !busy)
   `PTCD_ASSERT_SAME(a_reject_zero, reject_beat, reject_clean)

endmodule

bind per_thread_counter_delta_unit ptcd_checker u_ptcd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
